// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertions with an active-low asynchronous reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that prop never holds.
`define ASSERT_NEVER(lbl, clk, rst_n, prop, msg) \
  `ASSERT_CLK(lbl, clk, rst_n, !(prop), msg)

`endif

// ----- sv/sdct_pkg.sv -----
// ----------------------------------------------------------------------------
// sdct_pkg
// Types, opcodes, sense codes and response tables of the disk command target.
// ----------------------------------------------------------------------------
package sdct_pkg;

  localparam int unsigned DESCRIPTOR_MAX_DEF = 10;
  localparam int unsigned SECTOR_BYTES       = 512;
  localparam int unsigned CDB_BYTES          = 9;
  localparam int unsigned XFER_W             = 25;
  localparam int unsigned RLEN_W             = 7;
  localparam logic [31:0] XFER_MAX           = 32'h01FF_FFFF;
  localparam logic [23:0] SECTOR_B24         = 24'(SECTOR_BYTES);

  localparam logic [7:0] OP_TUR        = 8'h00;
  localparam logic [7:0] OP_REQ_SENSE  = 8'h03;
  localparam logic [7:0] OP_READ6      = 8'h08;
  localparam logic [7:0] OP_WRITE6     = 8'h0A;
  localparam logic [7:0] OP_INQUIRY    = 8'h12;
  localparam logic [7:0] OP_MSEL6      = 8'h15;
  localparam logic [7:0] OP_MSENSE6    = 8'h1A;
  localparam logic [7:0] OP_START_STOP = 8'h1B;
  localparam logic [7:0] OP_PREVENT    = 8'h1E;
  localparam logic [7:0] OP_READ_CAP   = 8'h25;
  localparam logic [7:0] OP_READ10     = 8'h28;
  localparam logic [7:0] OP_WRITE10    = 8'h2A;
  localparam logic [7:0] OP_SYNC_CACHE = 8'h35;
  localparam logic [7:0] OP_MSEL10     = 8'h55;
  localparam logic [7:0] OP_MSENSE10   = 8'h5A;

  localparam logic [5:0] PAGE_GEOMETRY = 6'h03;
  localparam logic [5:0] PAGE_RIGID    = 6'h04;
  localparam logic [5:0] PAGE_ALL      = 6'h3F;

  localparam logic [3:0] SK_NONE      = 4'h0;
  localparam logic [3:0] SK_NOT_READY = 4'h2;
  localparam logic [3:0] SK_ILLEGAL   = 4'h5;
  localparam logic [7:0] ASC_NONE       = 8'h00;
  localparam logic [7:0] ASC_NO_MEDIUM  = 8'h3A;
  localparam logic [7:0] ASC_BAD_LUN    = 8'h25;
  localparam logic [7:0] ASC_BAD_OPCODE = 8'h20;
  localparam logic [7:0] ASC_LBA_RANGE  = 8'h21;

  localparam logic REG_MEDIUM  = 1'b0;
  localparam logic REG_SECTORS = 1'b1;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_IN   = 2'd1,
    DIR_OUT  = 2'd2
  } dir_e;

  typedef enum logic [2:0] {
    RSP_NONE,
    RSP_SENSE,
    RSP_INQ,
    RSP_NODEV,
    RSP_MODE6,
    RSP_MODE10,
    RSP_CAP
  } rsp_e;

  typedef struct packed {
    logic       operation;
    logic [7:0] command_byte;
    logic       last_byte;
    logic [2:0] unit_number;
    logic [7:0] fetch_index;
  } cmd_t;

  typedef struct packed {
    logic              result_kind;
    logic              status_code;
    logic [1:0]        direction;
    logic              from_medium;
    logic [XFER_W-1:0] transfer_length;
    logic [31:0]       block_address;
    logic [15:0]       block_count;
    logic [7:0]        response_byte;
  } res_t;

  typedef struct packed {
    logic                       fetch;
    logic [7:0]                 fetch_index;
    logic [2:0]                 unit;
    logic [CDB_BYTES-1:0][7:0]  cdb;
  } job_t;

  localparam logic [8*28-1:0] INQ_ID = "EMULATEDSCSI DISK       1.0 ";

  function automatic logic [7:0] inq_byte(input logic [7:0] idx);
    logic [7:0] b;
    b = '0;
    if (idx >= 8'd8 && idx <= 8'd35) begin
      b = INQ_ID[8*(8'd35 - idx) +: 8];
    end else if (idx == 8'd2 || idx == 8'd3) begin
      b = 8'h02;
    end else if (idx == 8'd4) begin
      b = 8'h1F;
    end
    return b;
  endfunction

endpackage

// ----- sv/sdct_front.sv -----
// ----------------------------------------------------------------------------
// sdct_front
// Collects descriptor bytes and issues commands and fetches to the queue.
// ----------------------------------------------------------------------------
module sdct_front #(
  parameter int unsigned DescriptorMax = sdct_pkg::DESCRIPTOR_MAX_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  sdct_pkg::cmd_t cmd_i,
  output logic           push_o,
  output sdct_pkg::job_t job_o
);
  import sdct_pkg::*;

  localparam int unsigned IdxW = $clog2(DescriptorMax);
  localparam int unsigned CntW = $clog2(DescriptorMax + 1);

  logic [7:0]      desc_q [DescriptorMax];
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            byte_acc;
  logic            room;
  logic [CDB_BYTES-1:0][7:0] cdb;

  assign byte_acc = accept_i && !cmd_i.operation;
  assign room     = cnt_q < CntW'(DescriptorMax);

  for (genvar g = 0; g < CDB_BYTES; g++) begin : g_cdb
    if (g < DescriptorMax) begin : g_st
      assign cdb[g] = (CntW'(g) < cnt_q)  ? desc_q[g] :
                      (CntW'(g) == cnt_q) ? cmd_i.command_byte : 8'h00;
    end else begin : g_nost
      assign cdb[g] = 8'h00;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (byte_acc) begin
      if (cmd_i.last_byte) begin
        cnt_d = '0;
      end else if (room) begin
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_acc && room) begin
      desc_q[cnt_q[IdxW-1:0]] <= cmd_i.command_byte;
    end
  end

  assign push_o            = accept_i && (cmd_i.operation || cmd_i.last_byte);
  assign job_o.fetch       = cmd_i.operation;
  assign job_o.fetch_index = cmd_i.fetch_index;
  assign job_o.unit        = cmd_i.unit_number;
  assign job_o.cdb         = cdb;

endmodule

// ----- sv/sdct_fifo.sv -----
// ----------------------------------------------------------------------------
// sdct_fifo
// Two-entry queue of jobs between the front and the back.
// ----------------------------------------------------------------------------
module sdct_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sdct_pkg::job_t data_i,
  input  logic           pop_i,
  output logic           valid_o,
  output logic           full_o,
  output sdct_pkg::job_t data_o
);
  import sdct_pkg::*;

  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_pop;

  assign valid_o = cnt_q != 2'd0;
  assign full_o  = cnt_q == 2'd2;
  assign data_o  = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (do_pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ----- sv/sdct_back.sv -----
// ----------------------------------------------------------------------------
// sdct_back
// Executes commands, keeps sense and response state, serves fetches.
// ----------------------------------------------------------------------------
module sdct_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  sdct_pkg::job_t job_i,
  input  logic           medium_i,
  input  logic [31:0]    sectors_i,
  output logic           pop_o,
  output logic           res_valid_o,
  output sdct_pkg::res_t res_o
);
  import sdct_pkg::*;

  res_t              res_q, res_d;
  logic              res_valid_q;
  logic [3:0]        key_q, key_d;
  logic [7:0]        code_q, code_d, qual_q, qual_d;
  rsp_e              rsp_q, rsp_d;
  logic [RLEN_W-1:0] rlen_q, rlen_d;
  logic [3:0]        skey_q, skey_d;
  logic [7:0]        scode_q, scode_d, squal_q, squal_d;
  logic [31:0]       tot_q, tot_d;
  logic              dbd_q, dbd_d, pg3_q, pg3_d, pg4_q, pg4_d;
  logic [RLEN_W-1:0] mlen_q, mlen_d;
  logic [7:0]        fb;
  logic [20:0]       cyl;
  logic [31:0]       cap_last;

  assign pop_o    = valid_i;
  assign cyl      = tot_q[31:11];
  assign cap_last = (tot_q == 32'd0) ? 32'd0 : tot_q - 32'd1;

  always_comb begin
    logic [7:0] idx, hdr, bd, p0, p4, rel;
    idx = job_i.fetch_index;
    hdr = (rsp_q == RSP_MODE6) ? 8'd4 : 8'd8;
    bd  = dbd_q ? 8'd0 : 8'd8;
    p0  = hdr + bd;
    p4  = p0 + (pg3_q ? 8'd24 : 8'd0);
    rel = '0;
    fb  = '0;
    if (idx < {1'b0, rlen_q}) begin
      case (rsp_q)
        RSP_SENSE: begin
          case (idx)
            8'd0:    fb = 8'h70;
            8'd2:    fb = {4'h0, skey_q};
            8'd7:    fb = 8'h0A;
            8'd12:   fb = scode_q;
            8'd13:   fb = squal_q;
            default: fb = '0;
          endcase
        end
        RSP_INQ: fb = inq_byte(idx);
        RSP_NODEV: begin
          case (idx)
            8'd0:    fb = 8'h7F;
            8'd4:    fb = 8'h1F;
            default: fb = '0;
          endcase
        end
        RSP_CAP: begin
          case (idx)
            8'd0:    fb = cap_last[31:24];
            8'd1:    fb = cap_last[23:16];
            8'd2:    fb = cap_last[15:8];
            8'd3:    fb = cap_last[7:0];
            8'd5:    fb = SECTOR_B24[23:16];
            8'd6:    fb = SECTOR_B24[15:8];
            8'd7:    fb = SECTOR_B24[7:0];
            default: fb = '0;
          endcase
        end
        RSP_MODE6, RSP_MODE10: begin
          if (rsp_q == RSP_MODE6) begin
            if (idx == 8'd0) fb = {1'b0, mlen_q} - 8'd1;
            if (idx == 8'd3) fb = bd;
          end else begin
            if (idx == 8'd1) fb = {1'b0, mlen_q} - 8'd2;
            if (idx == 8'd7) fb = bd;
          end
          if (!dbd_q && idx >= hdr && idx < hdr + 8'd8) begin
            rel = idx - hdr;
            case (rel)
              8'd1:    fb = tot_q[23:16];
              8'd2:    fb = tot_q[15:8];
              8'd3:    fb = tot_q[7:0];
              8'd5:    fb = SECTOR_B24[23:16];
              8'd6:    fb = SECTOR_B24[15:8];
              8'd7:    fb = SECTOR_B24[7:0];
              default: fb = '0;
            endcase
          end
          if (pg3_q && idx >= p0 && idx < p0 + 8'd24) begin
            rel = idx - p0;
            case (rel)
              8'd0:    fb = 8'h03;
              8'd1:    fb = 8'd22;
              8'd11:   fb = 8'd32;
              8'd12:   fb = SECTOR_B24[15:8];
              8'd13:   fb = SECTOR_B24[7:0];
              default: fb = '0;
            endcase
          end
          if (pg4_q && idx >= p4 && idx < p4 + 8'd24) begin
            rel = idx - p4;
            case (rel)
              8'd0:    fb = 8'h04;
              8'd1:    fb = 8'd22;
              8'd2:    fb = {3'b000, cyl[20:16]};
              8'd3:    fb = cyl[15:8];
              8'd4:    fb = cyl[7:0];
              8'd5:    fb = 8'd64;
              8'd20:   fb = 8'h0E;
              8'd21:   fb = 8'h10;
              default: fb = '0;
            endcase
          end
        end
        default: fb = '0;
      endcase
    end
  end

  always_comb begin
    logic [7:0]  op, a8;
    logic        unit_ok, six, rd;
    logic [15:0] cnt16, a16, p16;
    logic [31:0] lba, prod;
    logic [32:0] lba_end;
    logic [5:0]  page;
    logic [1:0]  np;
    logic [RLEN_W-1:0] tot, n;
    op      = job_i.cdb[0];
    unit_ok = job_i.unit == 3'd0;
    six     = (op == OP_READ6) || (op == OP_WRITE6);
    rd      = (op == OP_READ6) || (op == OP_READ10);
    if (six) begin
      lba   = {11'b0, job_i.cdb[1][4:0], job_i.cdb[2], job_i.cdb[3]};
      cnt16 = (job_i.cdb[4] != 8'd0) ? {8'h00, job_i.cdb[4]} : 16'd256;
    end else begin
      lba   = {job_i.cdb[2], job_i.cdb[3], job_i.cdb[4], job_i.cdb[5]};
      cnt16 = {job_i.cdb[7], job_i.cdb[8]};
    end
    lba_end = {1'b0, lba} + {17'b0, cnt16};
    prod    = 32'(cnt16) * 32'(SECTOR_BYTES);
    page    = job_i.cdb[2][5:0];
    np      = {1'b0, page == PAGE_GEOMETRY || page == PAGE_ALL}
            + {1'b0, page == PAGE_RIGID || page == PAGE_ALL};
    tot     = ((op == OP_MSENSE6) ? RLEN_W'(4) : RLEN_W'(8))
            + (job_i.cdb[1][3] ? RLEN_W'(0) : RLEN_W'(8))
            + ((np == 2'd2) ? RLEN_W'(48) : (np == 2'd1) ? RLEN_W'(24) : RLEN_W'(0));
    p16     = (op == OP_MSEL6) ? {8'h00, job_i.cdb[4]} : {job_i.cdb[7], job_i.cdb[8]};
    a8      = '0;
    a16     = '0;
    n       = '0;

    res_d   = '0;
    key_d   = key_q;
    code_d  = code_q;
    qual_d  = qual_q;
    rsp_d   = rsp_q;
    rlen_d  = rlen_q;
    skey_d  = skey_q;
    scode_d = scode_q;
    squal_d = squal_q;
    tot_d   = tot_q;
    dbd_d   = dbd_q;
    pg3_d   = pg3_q;
    pg4_d   = pg4_q;
    mlen_d  = mlen_q;

    if (valid_i && job_i.fetch) begin
      res_d.result_kind   = 1'b1;
      res_d.response_byte = fb;
    end else if (valid_i) begin
      rsp_d = RSP_NONE;
      rlen_d = '0;
      tot_d = sectors_i;
      res_d.status_code = 1'b1;
      if (!medium_i) begin
        {key_d, code_d, qual_d} = {SK_NOT_READY, ASC_NO_MEDIUM, ASC_NONE};
      end else if (!unit_ok && op != OP_INQUIRY && op != OP_REQ_SENSE) begin
        {key_d, code_d, qual_d} = {SK_ILLEGAL, ASC_BAD_LUN, ASC_NONE};
      end else begin
        res_d.status_code = 1'b0;
        {key_d, code_d, qual_d} = {SK_NONE, ASC_NONE, ASC_NONE};
        unique case (op) inside
          OP_TUR, OP_START_STOP, OP_PREVENT, OP_SYNC_CACHE: ;
          OP_REQ_SENSE: begin
            a8 = (job_i.cdb[4] != 8'd0) ? job_i.cdb[4] : 8'd18;
            {skey_d, scode_d, squal_d} = {key_q, code_q, qual_q};
            rsp_d  = RSP_SENSE;
            rlen_d = (a8 < 8'd18) ? a8[RLEN_W-1:0] : RLEN_W'(18);
            res_d.direction       = DIR_IN;
            res_d.transfer_length = XFER_W'(a8);
          end
          OP_INQUIRY: begin
            a8 = (job_i.cdb[4] != 8'd0) ? job_i.cdb[4] : 8'd36;
            n  = (a8 < 8'd36) ? a8[RLEN_W-1:0] : RLEN_W'(36);
            if (!unit_ok) begin
              {key_d, code_d, qual_d} = {key_q, code_q, qual_q};
              rsp_d = RSP_NODEV;
            end else begin
              rsp_d = RSP_INQ;
            end
            rlen_d = n;
            res_d.direction       = DIR_IN;
            res_d.transfer_length = XFER_W'(n);
          end
          OP_MSEL6, OP_MSEL10: begin
            if (p16 != 16'd0) begin
              res_d.direction       = DIR_OUT;
              res_d.transfer_length = XFER_W'(p16);
            end
          end
          OP_MSENSE6, OP_MSENSE10: begin
            if (op == OP_MSENSE6) begin
              a16 = (job_i.cdb[4] != 8'd0) ? {8'h00, job_i.cdb[4]} : 16'd4;
            end else begin
              a16 = {job_i.cdb[7], job_i.cdb[8]};
              if (a16 == 16'd0) a16 = 16'd8;
            end
            n      = (a16 < 16'(tot)) ? a16[RLEN_W-1:0] : tot;
            rsp_d  = (op == OP_MSENSE6) ? RSP_MODE6 : RSP_MODE10;
            rlen_d = n;
            dbd_d  = job_i.cdb[1][3];
            pg3_d  = page == PAGE_GEOMETRY || page == PAGE_ALL;
            pg4_d  = page == PAGE_RIGID || page == PAGE_ALL;
            mlen_d = tot;
            res_d.direction       = DIR_IN;
            res_d.transfer_length = XFER_W'(n);
          end
          OP_READ_CAP: begin
            rsp_d  = RSP_CAP;
            rlen_d = RLEN_W'(8);
            res_d.direction       = DIR_IN;
            res_d.transfer_length = XFER_W'(8);
          end
          OP_READ6, OP_WRITE6, OP_READ10, OP_WRITE10: begin
            if (six || cnt16 != 16'd0) begin
              res_d.block_address = lba;
              res_d.block_count   = cnt16;
              if (lba_end > {1'b0, sectors_i}) begin
                res_d.status_code = 1'b1;
                {key_d, code_d, qual_d} = {SK_ILLEGAL, ASC_LBA_RANGE, ASC_NONE};
              end else begin
                res_d.direction       = rd ? DIR_IN : DIR_OUT;
                res_d.from_medium     = rd;
                res_d.transfer_length = (prod > XFER_MAX) ? {XFER_W{1'b1}}
                                                          : prod[XFER_W-1:0];
              end
            end
          end
          default: begin
            res_d.status_code = 1'b1;
            {key_d, code_d, qual_d} = {SK_ILLEGAL, ASC_BAD_OPCODE, ASC_NONE};
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      key_q       <= '0;
      code_q      <= '0;
      qual_q      <= '0;
      rsp_q       <= RSP_NONE;
      rlen_q      <= '0;
    end else begin
      res_valid_q <= valid_i;
      key_q       <= key_d;
      code_q      <= code_d;
      qual_q      <= qual_d;
      rsp_q       <= rsp_d;
      rlen_q      <= rlen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q   <= res_d;
    skey_q  <= skey_d;
    scode_q <= scode_d;
    squal_q <= squal_d;
    tot_q   <= tot_d;
    dbd_q   <= dbd_d;
    pg3_q   <= pg3_d;
    pg4_q   <= pg4_d;
    mlen_q  <= mlen_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ----- sv/scsi_disk_command_target.sv -----
// ----------------------------------------------------------------------------
// A command or fetch result passes through the job queue entry and then the result register.
// One item per cycle while busy is low; the back unit pops a job whenever the queue holds one.
// Descriptor bytes without the last-byte mark give no result.
// Reset clears control, sense and response length at once; no clearing pass.
// ----------------------------------------------------------------------------
// scsi_disk_command_target
// Direct-access disk target command decoder with an APB register port.
// ----------------------------------------------------------------------------
module scsi_disk_command_target #(
  parameter int unsigned DescriptorMax = sdct_pkg::DESCRIPTOR_MAX_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  sdct_pkg::cmd_t cmd_i,
  output logic           res_valid_o,
  output sdct_pkg::res_t res_o,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import sdct_pkg::*;

  logic        medium_q;
  logic [31:0] sectors_q;
  logic        accept, push, pop, q_valid, q_full;
  job_t        job_in, job_out;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SECTORS) ? sectors_q : {31'b0, medium_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      medium_q  <= 1'b0;
      sectors_q <= '0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_MEDIUM) begin
        medium_q <= pwdata[0];
      end else begin
        sectors_q <= pwdata;
      end
    end
  end

  assign busy   = q_full;
  assign accept = start && !busy;

  sdct_front #(.DescriptorMax(DescriptorMax)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .cmd_i    (cmd_i),
    .push_o   (push),
    .job_o    (job_in)
  );

  sdct_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .pop_i   (pop),
    .valid_o (q_valid),
    .full_o  (q_full),
    .data_o  (job_out)
  );

  sdct_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .job_i       (job_out),
    .medium_i    (medium_q),
    .sectors_i   (sectors_q),
    .pop_o       (pop),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

`include "assert_macros.svh"

  `ASSERT_CLK(a_fetch_clean, clk_i, rst_ni, (res_valid_o && res_o.result_kind) |-> (!res_o.status_code && res_o.direction == DIR_NONE && res_o.transfer_length == '0), "fetch result carries completion fields")
  `ASSERT_CLK(a_check_no_data, clk_i, rst_ni, (res_valid_o && res_o.status_code) |-> (res_o.direction == DIR_NONE), "check condition with a data phase")
  `ASSERT_CLK(a_medium_dir, clk_i, rst_ni, (res_valid_o && res_o.from_medium) |-> (res_o.direction == DIR_IN), "medium data without data-in")
  `ASSERT_NEVER(a_push_full, clk_i, rst_ni, push && q_full && !pop, "job queue overrun")

endmodule
